/* rtl/blt_pkg.sv */
// Shared types, register indexes, mode codes and lookup functions of the battery level tracker.
package blt_pkg;

    localparam int VW = 13;
    localparam int UW = 15;
    localparam int PW = 7;
    localparam int RW = 11;
    localparam int NW = 20;
    localparam int IW = 7;
    localparam int QSTEPS = 7;

    localparam logic [2:0] CFG_EMPTY      = 3'd0;
    localparam logic [2:0] CFG_LOW        = 3'd1;
    localparam logic [2:0] CFG_THIRD      = 3'd2;
    localparam logic [2:0] CFG_TWO_THIRDS = 3'd3;
    localparam logic [2:0] CFG_FULL       = 3'd4;
    localparam logic [2:0] CFG_USB        = 3'd5;

    localparam logic [1:0] MODE_OTHER    = 2'd0;
    localparam logic [1:0] MODE_DONTMOVE = 2'd1;
    localparam logic [1:0] MODE_ZONE     = 2'd2;
    localparam logic [1:0] MODE_TRACKING = 2'd3;

    localparam logic [1:0] TIER_LOW    = 2'd0;
    localparam logic [1:0] TIER_MEDIUM = 2'd1;
    localparam logic [1:0] TIER_HIGH   = 2'd2;
    localparam logic [1:0] TIER_FULL   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MED,
        S_UPD,
        S_PREP,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic med_step;
        logic update;
        logic prep;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic med_last;
        logic div_last;
        logic out_free;
    } t_status;

    function automatic logic [3:0] refresh_weight(input logic [RW-1:0] r);
        logic [3:0] w;
        w = 4'd0;
        case (r)
            11'd1, 11'd2, 11'd3, 11'd4, 11'd5: w = 4'd15;
            11'd10, 11'd15:                    w = 4'd12;
            11'd30, 11'd60:                    w = 4'd10;
            11'd120, 11'd180:                  w = 4'd6;
            11'd240, 11'd300, 11'd360:         w = 4'd5;
            11'd720:                           w = 4'd3;
            11'd1440:                          w = 4'd1;
            default:                           w = 4'd0;
        endcase
        return w;
    endfunction

    function automatic logic [RW-1:0] index_to_period(input logic [IW-1:0] idx);
        logic [RW-1:0] p;
        if (idx <= 7'd2) begin
            p = 11'd1440;
        end else if (idx <= 7'd5) begin
            p = 11'd720;
        end else if (idx <= 7'd10) begin
            p = 11'd360;
        end else if (idx <= 7'd15) begin
            p = 11'd180;
        end else if (idx <= 7'd20) begin
            p = 11'd60;
        end else begin
            p = 11'd30;
        end
        return p;
    endfunction

endpackage

/* rtl/blt_ctrl.sv */
// Sequencer of the battery level tracker: steps one item through median, update, divide and output.
module blt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  blt_pkg::t_status   i_status,
    output blt_pkg::t_cmd      o_cmd
);

    blt_pkg::t_state r_state;
    blt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= blt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            blt_pkg::S_IDLE: begin
                if (i_s_tvalid) n_state = blt_pkg::S_MED;
            end
            blt_pkg::S_MED: begin
                if (i_status.med_last) n_state = blt_pkg::S_UPD;
            end
            blt_pkg::S_UPD:  n_state = blt_pkg::S_PREP;
            blt_pkg::S_PREP: n_state = blt_pkg::S_DIV;
            blt_pkg::S_DIV: begin
                if (i_status.div_last) n_state = blt_pkg::S_FIN;
            end
            blt_pkg::S_FIN: begin
                if (i_status.out_free) n_state = blt_pkg::S_IDLE;
            end
            default: n_state = blt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            blt_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            blt_pkg::S_MED:  o_cmd.med_step = 1'b1;
            blt_pkg::S_UPD:  o_cmd.update = 1'b1;
            blt_pkg::S_PREP: o_cmd.prep = 1'b1;
            blt_pkg::S_DIV:  o_cmd.div_step = 1'b1;
            blt_pkg::S_FIN:  o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end

endmodule

/* rtl/blt_dp.sv */
// Datapath of the battery level tracker: window, median search, held voltage, divider, output register.
module blt_dp #(
    parameter int WINDOW_DEPTH = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [14:0]        i_cfg_data,
    input  logic [47:0]        i_s_tdata,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [39:0]        o_m_tdata,
    input  blt_pkg::t_cmd      i_cmd,
    output blt_pkg::t_status   o_status
);

    localparam int MIW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW  = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CW-1:0]  HALF = CW'(WINDOW_DEPTH / 2);
    localparam logic [MIW-1:0] LAST = MIW'(WINDOW_DEPTH - 1);

    logic [12:0] r_empty, r_low, r_third, r_two_thirds, r_full;
    logic [14:0] r_usb_thr;

    logic [12:0] r_win [WINDOW_DEPTH];
    logic        r_filled;
    logic [12:0] r_held;
    logic        r_sent;

    logic        r_chg, r_dev_on, r_psave, r_trk;
    logic [1:0]  r_kind;
    logic [10:0] r_refresh;

    logic [MIW-1:0] r_mi;
    logic [12:0]    r_med;
    logic           r_off, r_alert;
    logic [1:0]     r_tier;
    logic           r_pct_direct;
    logic [6:0]     r_pct_val;
    logic [19:0]    r_rem;
    logic [12:0]    r_den;
    logic [6:0]     r_q;
    logic [2:0]     r_k;

    logic           r_out_valid;
    logic [12:0]    r_out_volt;
    logic [6:0]     r_out_pct;
    logic [1:0]     r_out_tier;
    logic           r_out_off, r_out_alert, r_out_chg;
    logic [10:0]    r_out_period;

    logic [12:0]    s_sample;
    logic [12:0]    s_cand;
    logic [CW-1:0]  s_lt, s_le;
    logic [12:0]    s_held;
    logic [19:0]    s_trial;
    logic [6:0]     s_pct;
    logic [6:0]     s_idx_base, s_idx;

    assign s_sample = i_s_tdata[12:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty      <= 13'd3400;
            r_low        <= 13'd3650;
            r_third      <= 13'd3700;
            r_two_thirds <= 13'd3850;
            r_full       <= 13'd4100;
            r_usb_thr    <= 15'd4000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                blt_pkg::CFG_EMPTY:      r_empty      <= i_cfg_data[12:0];
                blt_pkg::CFG_LOW:        r_low        <= i_cfg_data[12:0];
                blt_pkg::CFG_THIRD:      r_third      <= i_cfg_data[12:0];
                blt_pkg::CFG_TWO_THIRDS: r_two_thirds <= i_cfg_data[12:0];
                blt_pkg::CFG_FULL:       r_full       <= i_cfg_data[12:0];
                blt_pkg::CFG_USB:        r_usb_thr    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // capture item and shift window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) r_win[i] <= '0;
            r_filled <= 1'b0;
        end else if (i_cmd.load) begin
            if (!r_filled) begin
                for (int i = 0; i < WINDOW_DEPTH; i++) r_win[i] <= s_sample;
            end else begin
                for (int i = 0; i < WINDOW_DEPTH - 1; i++) r_win[i] <= r_win[i+1];
                r_win[WINDOW_DEPTH-1] <= s_sample;
            end
            r_filled <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_chg     <= i_s_tdata[27:13] >= r_usb_thr;
            r_dev_on  <= i_s_tdata[28];
            r_psave   <= i_s_tdata[29];
            r_kind    <= i_s_tdata[31:30];
            r_trk     <= i_s_tdata[32];
            r_refresh <= i_s_tdata[43:33];
        end
    end

    // median: rank one candidate per cycle
    assign s_cand = r_win[r_mi];

    always_comb begin
        s_lt = '0;
        s_le = '0;
        for (int j = 0; j < WINDOW_DEPTH; j++) begin
            s_lt = s_lt + CW'(r_win[j] < s_cand);
            s_le = s_le + CW'(r_win[j] <= s_cand);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mi <= '0;
        end else if (i_cmd.med_step) begin
            r_mi <= r_mi + MIW'(1);
            if (s_lt <= HALF && s_le > HALF) r_med <= s_cand;
        end
    end

    always_comb begin
        s_held = r_held;
        if ((r_chg && r_med > r_held) || (!r_chg && r_med < r_held) || r_held == '0) begin
            s_held = r_med;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_sent <= 1'b0;
        end else if (i_cmd.update) begin
            r_held <= s_held;
            if (r_dev_on) begin
                if (s_held <= r_empty) begin
                    r_sent <= r_sent;
                end else if (s_held <= r_low && !r_chg && !r_sent) begin
                    r_sent <= 1'b1;
                end else if (s_held > r_low) begin
                    r_sent <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_off   <= r_dev_on && s_held <= r_empty;
            r_alert <= r_dev_on && s_held > r_empty && s_held <= r_low && !r_chg && !r_sent;
        end
    end

    // tier, percentage special cases, divider setup
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            if (r_held < r_third) begin
                r_tier <= blt_pkg::TIER_LOW;
            end else if (r_held < r_two_thirds) begin
                r_tier <= blt_pkg::TIER_MEDIUM;
            end else if (r_held < r_full) begin
                r_tier <= blt_pkg::TIER_HIGH;
            end else begin
                r_tier <= blt_pkg::TIER_FULL;
            end
            if (r_full <= r_empty) begin
                r_pct_direct <= 1'b1;
                r_pct_val    <= (r_held > r_empty) ? 7'd100 : 7'd0;
            end else if (r_held <= r_empty) begin
                r_pct_direct <= 1'b1;
                r_pct_val    <= 7'd0;
            end else if (r_held >= r_full) begin
                r_pct_direct <= 1'b1;
                r_pct_val    <= 7'd100;
            end else begin
                r_pct_direct <= 1'b0;
                r_pct_val    <= 7'd0;
            end
            r_rem <= 20'(r_held - r_empty) * 20'd100;
            r_den <= r_full - r_empty;
            r_q   <= '0;
            r_k   <= 3'(blt_pkg::QSTEPS - 1);
        end else if (i_cmd.div_step) begin
            if (r_rem >= s_trial) begin
                r_rem    <= r_rem - s_trial;
                r_q[r_k] <= 1'b1;
            end
            r_k <= r_k - 3'd1;
        end
    end

    assign s_trial = 20'(r_den) << r_k;

    // consumption index and output register
    assign s_pct = r_pct_direct ? r_pct_val : r_q;

    always_comb begin
        s_idx_base = r_chg ? 7'd20 : 7'd0;
        if (r_dev_on && !r_psave) s_idx_base = s_idx_base + 7'd5;
        if (r_kind == blt_pkg::MODE_DONTMOVE && !r_trk) begin
            s_idx_base = s_idx_base + 7'd1;
        end else if (r_kind == blt_pkg::MODE_ZONE && !r_trk) begin
            s_idx_base = s_idx_base + 7'd8;
        end else if (r_kind != blt_pkg::MODE_OTHER) begin
            s_idx_base = s_idx_base + 7'(blt_pkg::refresh_weight(r_refresh));
        end
        s_idx = (s_pct <= 7'd20) ? (s_idx_base << 1) : s_idx_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_volt   <= r_held;
            r_out_pct    <= s_pct;
            r_out_tier   <= r_tier;
            r_out_off    <= r_off;
            r_out_alert  <= r_alert;
            r_out_chg    <= r_chg;
            r_out_period <= blt_pkg::index_to_period(s_idx);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_chg, r_out_period, r_out_alert, r_out_off,
                         r_out_tier, r_out_pct, r_out_volt};

    assign o_status.med_last = (r_mi == LAST);
    assign o_status.div_last = (r_k == 3'd0);
    assign o_status.out_free = !r_out_valid || i_m_tready;

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_pct <= 7'd100)
        else $error("percent above one hundred");

    a_off_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_off && r_out_alert))
        else $error("turn-off and alert raised together");

    a_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> r_filled)
        else $error("window not marked filled after an item");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("output register overwritten while held");

endmodule

/* rtl/battery_level_tracker.sv */
// Top level of the battery level tracker: sequencer plus datapath.
// Items are taken one at a time: a new item is accepted only once the previous result has been
// loaded into the output register. The median search ranks one window
// entry per cycle and the percentage divider resolves one quotient bit per cycle.
// The output register holds a result while the next item is taken.
// Reset (synchronous, active low) restores register defaults, clears window and held voltage.
module battery_level_tracker #(
    parameter int WINDOW_DEPTH = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // battery_sample, usb_voltage, device_on, power_saving, mode_kind,
    // mode_tracking_state, refresh_minutes
    input  logic [47:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // shown_voltage, percent, led_tier, turn_off_request, low_alert, check_period, charging
    output logic [39:0] o_m_tdata
);

    blt_pkg::t_cmd    s_cmd;
    blt_pkg::t_status s_status;

    blt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (s_status),
        .o_cmd      (s_cmd)
    );

    blt_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cmd      (s_cmd),
        .o_status   (s_status)
    );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench of the battery level tracker: stream driver, monitor and predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_DEPTH = 3;
    localparam int IDLE_LIMIT   = 3000;

    typedef struct packed {
        logic [10:0] refresh_min;
        logic        trk_state;
        logic [1:0]  kind;
        logic        psave;
        logic        dev_on;
        logic [14:0] usb;
        logic [12:0] sample_mv;
    } t_sample;

    typedef struct packed {
        logic        chg;
        logic [10:0] period;
        logic        alert;
        logic        off_req;
        logic [1:0]  tier;
        logic [6:0]  pct;
        logic [12:0] shown_mv;
    } t_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [14:0] i_cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] s_tdata = '0;
    logic        o_m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] o_m_tdata;

    t_sample pending_samples[$];
    t_report due_reports[$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    int      gap_left = 0;
    int      stall_left = 0;
    int      gap_pct = 0;
    int      stall_pct = 0;

    int lvl_empty = 3400;
    int lvl_low = 3650;
    int lvl_third = 3700;
    int lvl_two_thirds = 3850;
    int lvl_full = 4100;
    int usb_thresh = 4000;

    logic [12:0] win_mv[WINDOW_DEPTH];
    logic        win_full = 1'b0;
    logic [12:0] held_mv = '0;
    logic        alert_latched = 1'b0;

    int  walk_mv = 3800;
    logic walk_chg = 1'b0;

    battery_level_tracker #(.WINDOW_DEPTH(WINDOW_DEPTH)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int rate_weight(int r);
        case (r)
            1, 2, 3, 4, 5:   return 15;
            10, 15:          return 12;
            30, 60:          return 10;
            120, 180:        return 6;
            240, 300, 360:   return 5;
            720:             return 3;
            1440:            return 1;
            default:         return 0;
        endcase
    endfunction

    function automatic t_report track_battery(t_sample s);
        t_report     r;
        logic [12:0] srt[WINDOW_DEPTH];
        logic [12:0] tmp;
        logic [12:0] med;
        int          pct;
        int          idx;
        int          fac;
        logic        chg;
        chg = (int'(s.usb) >= usb_thresh);
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) win_mv[i] = win_mv[i + 1];
        win_mv[WINDOW_DEPTH - 1] = s.sample_mv;
        if (!win_full) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) win_mv[i] = s.sample_mv;
            win_full = 1'b1;
        end
        srt = win_mv;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            for (int j = 0; j < WINDOW_DEPTH - 1 - i; j++) begin
                if (srt[j] > srt[j + 1]) begin
                    tmp = srt[j];
                    srt[j] = srt[j + 1];
                    srt[j + 1] = tmp;
                end
            end
        end
        med = srt[WINDOW_DEPTH / 2];
        if ((chg && med > held_mv) || (!chg && med < held_mv) || held_mv == 0) held_mv = med;

        r = '0;
        if (s.dev_on) begin
            if (held_mv <= lvl_empty) begin
                r.off_req = 1'b1;
            end else if (held_mv <= lvl_low && !chg && !alert_latched) begin
                r.alert = 1'b1;
                alert_latched = 1'b1;
            end else if (held_mv > lvl_low) begin
                alert_latched = 1'b0;
            end
        end

        if (lvl_full <= lvl_empty) pct = (held_mv > lvl_empty) ? 100 : 0;
        else if (held_mv <= lvl_empty) pct = 0;
        else if (held_mv >= lvl_full) pct = 100;
        else pct = ((held_mv - lvl_empty) * 100) / (lvl_full - lvl_empty);

        if (held_mv < lvl_third) r.tier = blt_pkg::TIER_LOW;
        else if (held_mv < lvl_two_thirds) r.tier = blt_pkg::TIER_MEDIUM;
        else if (held_mv < lvl_full) r.tier = blt_pkg::TIER_HIGH;
        else r.tier = blt_pkg::TIER_FULL;

        idx = chg ? 20 : 0;
        fac = (pct <= 20) ? 2 : 1;
        if (s.dev_on && !s.psave) idx += 5;
        if (s.kind == blt_pkg::MODE_DONTMOVE && !s.trk_state) idx += 1;
        else if (s.kind == blt_pkg::MODE_ZONE && !s.trk_state) idx += 8;
        else if (s.kind == blt_pkg::MODE_TRACKING ||
                 (s.kind != blt_pkg::MODE_OTHER && s.trk_state))
            idx += rate_weight(s.refresh_min);
        idx *= fac;

        if (idx <= 2) r.period = 11'd1440;
        else if (idx <= 5) r.period = 11'd720;
        else if (idx <= 10) r.period = 11'd360;
        else if (idx <= 15) r.period = 11'd180;
        else if (idx <= 20) r.period = 11'd60;
        else r.period = 11'd30;

        r.shown_mv = held_mv;
        r.pct = pct[6:0];
        r.chg = chg;
        return r;
    endfunction

    function automatic int pick_pause(int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin : drive_items
        logic fire;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            fire = s_tvalid && o_s_tready;
            if (fire) begin
                due_reports.push_back(track_battery(pending_samples.pop_front()));
                gap_left = pick_pause(gap_pct);
            end
            if (s_tvalid && !fire) begin
                // hold the presented item
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= {4'b0, pending_samples[0]};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = pick_pause(stall_pct);
            m_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch_results
        t_report got;
        t_report want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            got = o_m_tdata[35:0];
            if (due_reports.size() == 0) begin
                $error("result item arrived with none outstanding");
                mismatches++;
            end else begin
                want = due_reports.pop_front();
                check_field("shown_voltage", 16'(want.shown_mv), 16'(got.shown_mv));
                check_field("percent", 16'(want.pct), 16'(got.pct));
                check_field("led_tier", 16'(want.tier), 16'(got.tier));
                check_field("turn_off_request", 16'(want.off_req), 16'(got.off_req));
                check_field("low_alert", 16'(want.alert), 16'(got.alert));
                check_field("check_period", 16'(want.period), 16'(got.period));
                check_field("charging", 16'(want.chg), 16'(got.chg));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) ||
            (pending_samples.size() == 0 && due_reports.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic void add_item(int mv, int usb, int on, int ps, logic [1:0] kind,
                                     int trk, int refresh);
        t_sample s;
        s.sample_mv = mv[12:0];
        s.usb = usb[14:0];
        s.dev_on = on[0];
        s.psave = ps[0];
        s.kind = kind;
        s.trk_state = trk[0];
        s.refresh_min = refresh[10:0];
        pending_samples.push_back(s);
    endfunction

    task automatic write_reg(logic [2:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[14:0];
        case (idx)
            blt_pkg::CFG_EMPTY:      lvl_empty = val & 13'h1FFF;
            blt_pkg::CFG_LOW:        lvl_low = val & 13'h1FFF;
            blt_pkg::CFG_THIRD:      lvl_third = val & 13'h1FFF;
            blt_pkg::CFG_TWO_THIRDS: lvl_two_thirds = val & 13'h1FFF;
            blt_pkg::CFG_FULL:       lvl_full = val & 13'h1FFF;
            blt_pkg::CFG_USB:        usb_thresh = val & 15'h7FFF;
            default: ;
        endcase
    endtask

    task automatic write_levels(int e, int l, int t, int w, int f, int u);
        write_reg(blt_pkg::CFG_EMPTY, e);
        write_reg(blt_pkg::CFG_LOW, l);
        write_reg(blt_pkg::CFG_THIRD, t);
        write_reg(blt_pkg::CFG_TWO_THIRDS, w);
        write_reg(blt_pkg::CFG_FULL, f);
        write_reg(blt_pkg::CFG_USB, u);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic settle();
        while (pending_samples.size() != 0 || due_reports.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    function automatic void queue_random(int n);
        int lo;
        int hi;
        int usb;
        int step;
        int refresh;
        int rates[17] = '{1, 2, 3, 4, 5, 10, 15, 30, 60, 120, 180, 240, 300, 360, 720, 1440, 0};
        lo = (lvl_empty < lvl_full ? lvl_empty : lvl_full) - 300;
        hi = (lvl_empty > lvl_full ? lvl_empty : lvl_full) + 300;
        if (lo < 0) lo = 0;
        if (hi > 8191) hi = 8191;
        if (walk_mv < lo || walk_mv > hi) walk_mv = $urandom_range(hi, lo);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 10) walk_chg = ~walk_chg;
            if (usb_thresh == 0) walk_chg = 1'b1;
            if (walk_chg) begin
                usb = $urandom_range(usb_thresh, usb_thresh + 500 > 32767 ? 32767
                                                                          : usb_thresh + 500);
            end else begin
                usb = $urandom_range(usb_thresh - 1, usb_thresh > 500 ? usb_thresh - 500 : 0);
            end
            step = $urandom_range(60);
            walk_mv += walk_chg ? step - 15 : 15 - step;
            if (walk_mv < lo) walk_mv = lo;
            if (walk_mv > hi) walk_mv = hi;
            refresh = ($urandom_range(1)) ? rates[$urandom_range(16)] : $urandom_range(2047);
            if ($urandom_range(99) < 15) begin
                add_item($urandom_range(8191), $urandom_range(32767), $urandom_range(1),
                         $urandom_range(1), 2'($urandom_range(3)), $urandom_range(1),
                         refresh);
            end else begin
                add_item(walk_mv, usb, int'($urandom_range(99) < 85), $urandom_range(1),
                         2'($urandom_range(3)), $urandom_range(1), refresh);
            end
        end
    endfunction

    initial begin
        int e;
        int f;
        for (int i = 0; i < WINDOW_DEPTH; i++) win_mv[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        gap_pct = 30;
        stall_pct = 30;
        add_item(3900, 0, 1, 0, blt_pkg::MODE_OTHER, 0, 0);
        add_item(0, 0, 1, 0, blt_pkg::MODE_DONTMOVE, 0, 0);
        add_item(0, 0, 1, 0, blt_pkg::MODE_DONTMOVE, 1, 5);
        add_item(8191, 32767, 1, 1, blt_pkg::MODE_ZONE, 0, 1);
        add_item(8191, 4000, 1, 0, blt_pkg::MODE_ZONE, 1, 10);
        add_item(3650, 3999, 1, 0, blt_pkg::MODE_TRACKING, 1, 1440);
        add_item(3650, 3999, 1, 0, blt_pkg::MODE_TRACKING, 0, 720);
        add_item(3650, 0, 1, 0, blt_pkg::MODE_TRACKING, 0, 7);
        add_item(3660, 0, 0, 0, blt_pkg::MODE_OTHER, 0, 2047);
        add_item(3400, 0, 1, 1, blt_pkg::MODE_DONTMOVE, 1, 60);
        add_item(3400, 0, 1, 0, blt_pkg::MODE_ZONE, 1, 120);
        add_item(3400, 0, 0, 0, blt_pkg::MODE_TRACKING, 0, 180);
        add_item(3800, 4000, 1, 0, blt_pkg::MODE_TRACKING, 1, 240);
        add_item(3800, 4000, 1, 0, blt_pkg::MODE_DONTMOVE, 1, 300);
        add_item(3640, 0, 1, 0, blt_pkg::MODE_ZONE, 1, 360);
        add_item(3640, 0, 1, 1, blt_pkg::MODE_DONTMOVE, 1, 15);
        add_item(4200, 32767, 1, 0, blt_pkg::MODE_TRACKING, 0, 30);
        add_item(4200, 32767, 0, 1, blt_pkg::MODE_OTHER, 1, 2);
        add_item(4100, 20000, 1, 0, blt_pkg::MODE_TRACKING, 0, 1024);
        add_item(3700, 100, 1, 0, blt_pkg::MODE_ZONE, 0, 3);
        settle();

        gap_pct = 0;
        stall_pct = 0;
        write_levels(3400, 3650, 3700, 3850, 4100, 4000);
        queue_random(150);
        settle();

        gap_pct = 40;
        stall_pct = 60;
        write_levels(0, 0, 0, 0, 0, 0);
        queue_random(60);
        settle();

        gap_pct = 60;
        stall_pct = 20;
        write_levels(8191, 8191, 8191, 8191, 8191, 32767);
        queue_random(60);
        settle();

        gap_pct = 20;
        stall_pct = 40;
        write_levels(4000, 3800, 3900, 3600, 3500, 100);
        queue_random(80);
        settle();

        for (int p = 0; p < 5; p++) begin
            gap_pct = (p % 2) ? 0 : $urandom_range(60);
            stall_pct = (p % 2) ? 0 : $urandom_range(60);
            e = $urandom_range(3500, 3000);
            f = $urandom_range(4300, 3900);
            write_levels(e, $urandom_range(e + 400, e), $urandom_range(f, e),
                         $urandom_range(f, e), f, $urandom_range(32767));
            queue_random(90);
            settle();
        end

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/blt_pkg.sv
rtl/blt_ctrl.sv
rtl/blt_dp.sv
rtl/battery_level_tracker.sv
sim/tb_top.sv
